// ===== design/csg_pkg.sv =====
// ----------------------------------------------------------------------------
// csg_pkg
// shared types, sizes and codes of the chunked sparse grid cell store
// ----------------------------------------------------------------------------
package csg_pkg;

    localparam int TILE_WIDTH_LOG2  = 6;
    localparam int TILE_HEIGHT_LOG2 = 6;
    localparam int MAX_TILES        = 16;

    localparam int CELL_AW   = TILE_WIDTH_LOG2 + TILE_HEIGHT_LOG2;
    localparam int CELLS     = 1 << CELL_AW;
    localparam int SLOT_W    = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int CNT_W     = $clog2(MAX_TILES + 1);
    localparam int LIVE_W    = CELL_AW + 1;
    localparam int MEM_AW    = SLOT_W + CELL_AW;
    localparam int MEM_DEPTH = MAX_TILES * CELLS;
    localparam int TOTAL_W   = 17;
    localparam int MAT_W     = 16;
    localparam int PADDR_W   = 3;

    localparam logic [2:0] OP_GET    = 3'd0;
    localparam logic [2:0] OP_SET    = 3'd1;
    localparam logic [2:0] OP_CLEAR  = 3'd2;
    localparam logic [2:0] OP_LOAD   = 3'd3;
    localparam logic [2:0] OP_UNLOAD = 3'd4;
    localparam logic [2:0] OP_STEP   = 3'd5;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_EXISTS    = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    localparam logic REG_MATERIALS = 1'b0;

    typedef struct packed {
        logic [2:0]        opcode;
        logic signed [31:0] cell_x;
        logic signed [31:0] cell_y;
        logic signed [31:0] tile_x;
        logic signed [31:0] tile_y;
        logic [15:0]       write_id;
        logic [31:0]       substeps;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] read_material;
        logic [4:0]  tiles_loaded;
        logic [4:0]  tiles_live;
        logic [16:0] live_total;
        logic [63:0] step_total;
    } res_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [MEM_AW-1:0] addr;
        logic [MAT_W-1:0]  wdata;
    } mem_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_LOOKUP,
        S_EXEC,
        S_CLEAR,
        S_RESULT
    } state_t;

endpackage

// ===== design/chunked_sparse_grid_cell_store_top.sv =====
// ----------------------------------------------------------------------------
// chunked_sparse_grid_cell_store_top
// flow: a word passes through match and lookup, then execute for a cell access that hits
// a chunk, then result; a chunk load clears its chunk, one cell store entry cleared per cycle
// one word in flight: the next word is accepted in the cycle after its result is
// registered; a stalled result holds back the next one
// reset: asynchronous, clears table count, free map, counts, step counter and register
// ----------------------------------------------------------------------------
module chunked_sparse_grid_cell_store_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  csg_pkg::cmd_t                 cmd,
    output logic                          res_valid,
    input  logic                          res_ready,
    output csg_pkg::res_t                 res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [csg_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int NT = csg_pkg::MAX_TILES;

    csg_pkg::state_t                      state_reg, state_next;
    csg_pkg::cmd_t                        cmd_reg, cmd_next;
    csg_pkg::res_t                        res_reg, res_next;
    logic                                 res_valid_reg, res_valid_next;
    logic [15:0]                          mat_reg;
    logic [1:0]                           status_reg, status_next;
    logic [15:0]                          readv_reg, readv_next;
    logic [NT-1:0]                        hit_reg, hit_next;
    logic [NT-1:0]                        free_reg, free_next;
    logic [csg_pkg::CNT_W-1:0]            count_reg, count_next;
    logic [csg_pkg::CNT_W-1:0]            active_reg, active_next;
    logic [csg_pkg::TOTAL_W-1:0]          total_reg, total_next;
    logic [63:0]                          step_reg, step_next;
    logic [csg_pkg::LIVE_W-1:0]           live_reg [NT];
    logic [csg_pkg::LIVE_W-1:0]           live_next [NT];
    logic [63:0]                          key_reg [NT];
    logic [63:0]                          key_next [NT];
    logic [csg_pkg::SLOT_W-1:0]           tslot_reg [NT];
    logic [csg_pkg::SLOT_W-1:0]           tslot_next [NT];
    logic [csg_pkg::SLOT_W-1:0]           slot_sel_reg, slot_sel_next;
    logic [csg_pkg::MEM_AW-1:0]           addr_reg, addr_next;
    logic [csg_pkg::CELL_AW-1:0]          clr_reg, clr_next;

    csg_pkg::mem_req_t                    mem_req;
    logic [csg_pkg::MAT_W-1:0]            mem_rdata;

    logic [63:0]                          key_sel;
    logic [csg_pkg::SLOT_W-1:0]           e_idx;
    logic [csg_pkg::SLOT_W-1:0]           free_idx;
    logic                                 free_any;
    logic [csg_pkg::SLOT_W-1:0]           slot_e;
    logic [csg_pkg::LIVE_W-1:0]           lv;
    logic [csg_pkg::CNT_W-1:0]            last_idx;
    logic [31:0]                          tx_fl, ty_fl;
    logic [15:0]                          wv;

    csg_cell_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == csg_pkg::REG_MATERIALS) ? {16'd0, mat_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[2] == csg_pkg::REG_MATERIALS)
        begin
            mat_reg <= pwdata[15:0];
        end
    end

    // tile key of the current word
    assign tx_fl = 32'($signed(cmd_reg.cell_x) >>> csg_pkg::TILE_WIDTH_LOG2);
    assign ty_fl = 32'($signed(cmd_reg.cell_y) >>> csg_pkg::TILE_HEIGHT_LOG2);

    always_comb
    begin
        if (cmd_reg.opcode == csg_pkg::OP_GET || cmd_reg.opcode == csg_pkg::OP_SET
            || cmd_reg.opcode == csg_pkg::OP_CLEAR)
        begin
            key_sel = {tx_fl, ty_fl};
        end
        else
        begin
            key_sel = {cmd_reg.tile_x, cmd_reg.tile_y};
        end
    end

    always_comb
    begin
        e_idx = '0;
        free_idx = '0;
        for (int i = NT - 1; i >= 0; i--)
        begin
            if (hit_reg[i])
            begin
                e_idx = csg_pkg::SLOT_W'(i);
            end
            if (free_reg[i])
            begin
                free_idx = csg_pkg::SLOT_W'(i);
            end
        end
    end

    assign free_any = |free_reg;
    assign slot_e   = tslot_reg[e_idx];
    assign lv       = live_reg[slot_e];
    assign last_idx = count_reg - csg_pkg::CNT_W'(1);
    assign wv       = (cmd_reg.opcode == csg_pkg::OP_SET) ? cmd_reg.write_id : 16'd0;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        status_next    = status_reg;
        readv_next     = readv_reg;
        hit_next       = hit_reg;
        free_next      = free_reg;
        count_next     = count_reg;
        active_next    = active_reg;
        total_next     = total_reg;
        step_next      = step_reg;
        slot_sel_next  = slot_sel_reg;
        addr_next      = addr_reg;
        clr_next       = clr_reg;
        live_next      = live_reg;
        key_next       = key_reg;
        tslot_next     = tslot_reg;
        mem_req        = '0;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            csg_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next    = cmd;
                    status_next = csg_pkg::STAT_OK;
                    readv_next  = '0;
                    state_next  = csg_pkg::S_MATCH;
                end
            end
            csg_pkg::S_MATCH:
            begin
                for (int i = 0; i < NT; i++)
                begin
                    hit_next[i] = (csg_pkg::CNT_W'(i) < count_reg) && (key_reg[i] == key_sel);
                end
                state_next = csg_pkg::S_LOOKUP;
            end
            csg_pkg::S_LOOKUP:
            begin
                state_next = csg_pkg::S_RESULT;
                priority case (cmd_reg.opcode)
                    csg_pkg::OP_GET, csg_pkg::OP_SET, csg_pkg::OP_CLEAR:
                    begin
                        if (cmd_reg.opcode == csg_pkg::OP_SET && cmd_reg.write_id != 16'd0
                            && cmd_reg.write_id > mat_reg)
                        begin
                            status_next = csg_pkg::STAT_NOT_FOUND;
                        end
                        else if (!(|hit_reg))
                        begin
                            status_next = csg_pkg::STAT_NOT_FOUND;
                        end
                        else
                        begin
                            addr_next = {slot_e,
                                         cmd_reg.cell_y[csg_pkg::TILE_HEIGHT_LOG2-1:0],
                                         cmd_reg.cell_x[csg_pkg::TILE_WIDTH_LOG2-1:0]};
                            mem_req.en   = 1'b1;
                            mem_req.addr = {slot_e,
                                            cmd_reg.cell_y[csg_pkg::TILE_HEIGHT_LOG2-1:0],
                                            cmd_reg.cell_x[csg_pkg::TILE_WIDTH_LOG2-1:0]};
                            slot_sel_next = slot_e;
                            state_next    = csg_pkg::S_EXEC;
                        end
                    end
                    csg_pkg::OP_LOAD:
                    begin
                        if (|hit_reg)
                        begin
                            status_next = csg_pkg::STAT_EXISTS;
                        end
                        else if (count_reg >= csg_pkg::CNT_W'(NT) || !free_any)
                        begin
                            status_next = csg_pkg::STAT_FULL;
                        end
                        else
                        begin
                            free_next[free_idx] = 1'b0;
                            live_next[free_idx] = '0;
                            key_next[count_reg[csg_pkg::SLOT_W-1:0]]   = key_sel;
                            tslot_next[count_reg[csg_pkg::SLOT_W-1:0]] = free_idx;
                            count_next    = count_reg + csg_pkg::CNT_W'(1);
                            slot_sel_next = free_idx;
                            clr_next      = '0;
                            state_next    = csg_pkg::S_CLEAR;
                        end
                    end
                    csg_pkg::OP_UNLOAD:
                    begin
                        if (!(|hit_reg))
                        begin
                            status_next = csg_pkg::STAT_NOT_FOUND;
                        end
                        else
                        begin
                            if (lv != '0)
                            begin
                                total_next = (32'(total_reg) >= 32'(lv))
                                    ? csg_pkg::TOTAL_W'(32'(total_reg) - 32'(lv)) : '0;
                                if (active_reg != '0)
                                begin
                                    active_next = active_reg - csg_pkg::CNT_W'(1);
                                end
                            end
                            live_next[slot_e] = '0;
                            free_next[slot_e] = 1'b1;
                            if (csg_pkg::CNT_W'(e_idx) < last_idx)
                            begin
                                key_next[e_idx]   = key_reg[last_idx[csg_pkg::SLOT_W-1:0]];
                                tslot_next[e_idx] = tslot_reg[last_idx[csg_pkg::SLOT_W-1:0]];
                            end
                            count_next = last_idx;
                        end
                    end
                    csg_pkg::OP_STEP:
                    begin
                        step_next = step_reg + ((cmd_reg.substeps == 32'd0)
                                                ? 64'd1 : 64'(cmd_reg.substeps));
                    end
                    default:
                    begin
                        status_next = csg_pkg::STAT_OK;
                    end
                endcase
            end
            csg_pkg::S_EXEC:
            begin
                state_next = csg_pkg::S_RESULT;
                if (cmd_reg.opcode == csg_pkg::OP_GET)
                begin
                    readv_next = mem_rdata;
                    if (mem_rdata != 16'd0 && mem_rdata > mat_reg)
                    begin
                        status_next = csg_pkg::STAT_NOT_FOUND;
                    end
                end
                else
                begin
                    mem_req.en    = 1'b1;
                    mem_req.we    = 1'b1;
                    mem_req.addr  = addr_reg;
                    mem_req.wdata = wv;
                    if (mem_rdata == 16'd0 && wv != 16'd0)
                    begin
                        total_next = total_reg + csg_pkg::TOTAL_W'(1);
                        live_next[slot_sel_reg] = live_reg[slot_sel_reg] + csg_pkg::LIVE_W'(1);
                        if (live_reg[slot_sel_reg] == '0)
                        begin
                            active_next = active_reg + csg_pkg::CNT_W'(1);
                        end
                    end
                    else if (mem_rdata != 16'd0 && wv == 16'd0)
                    begin
                        if (total_reg != '0)
                        begin
                            total_next = total_reg - csg_pkg::TOTAL_W'(1);
                        end
                        if (live_reg[slot_sel_reg] != '0)
                        begin
                            live_next[slot_sel_reg] = live_reg[slot_sel_reg] - csg_pkg::LIVE_W'(1);
                            if (live_reg[slot_sel_reg] == csg_pkg::LIVE_W'(1)
                                && active_reg != '0)
                            begin
                                active_next = active_reg - csg_pkg::CNT_W'(1);
                            end
                        end
                    end
                end
            end
            csg_pkg::S_CLEAR:
            begin
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = {slot_sel_reg, clr_reg};
                mem_req.wdata = '0;
                clr_next      = clr_reg + csg_pkg::CELL_AW'(1);
                if (clr_reg == '1)
                begin
                    state_next = csg_pkg::S_RESULT;
                end
            end
            csg_pkg::S_RESULT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_next.status        = status_reg;
                    res_next.read_material = readv_reg;
                    res_next.tiles_loaded  = 5'(count_reg);
                    res_next.tiles_live    = 5'(active_reg);
                    res_next.live_total    = total_reg;
                    res_next.step_total    = step_reg;
                    res_valid_next         = 1'b1;
                    state_next             = csg_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = csg_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csg_pkg::S_IDLE;
            res_valid_reg <= 1'b0;
            free_reg      <= '1;
            count_reg     <= '0;
            active_reg    <= '0;
            total_reg     <= '0;
            step_reg      <= '0;
            for (int i = 0; i < NT; i++)
            begin
                live_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            active_reg    <= active_next;
            total_reg     <= total_next;
            step_reg      <= step_next;
            live_reg      <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        res_reg      <= res_next;
        status_reg   <= status_next;
        readv_reg    <= readv_next;
        hit_reg      <= hit_next;
        slot_sel_reg <= slot_sel_next;
        addr_reg     <= addr_next;
        clr_reg      <= clr_next;
        key_reg      <= key_next;
        tslot_reg    <= tslot_next;
    end

    assign cmd_ready = (state_reg == csg_pkg::S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== design/csg_cell_mem.sv =====
// ----------------------------------------------------------------------------
// csg_cell_mem
// single-port cell store, one access per cycle, registered read data
// ----------------------------------------------------------------------------
module csg_cell_mem (
    input  logic                            clk,
    input  csg_pkg::mem_req_t               req,
    output logic [csg_pkg::MAT_W-1:0]       rdata
);

    logic [csg_pkg::MAT_W-1:0] cell_mem [csg_pkg::MEM_DEPTH];
    logic [csg_pkg::MAT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                cell_mem[req.addr] <= req.wdata;
            end
            rdata_reg <= cell_mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/csg_checker.sv =====
// ----------------------------------------------------------------------------
// csg_checker
// port-level checks of the cell store, attached to the top level by bind
// ----------------------------------------------------------------------------
module csg_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_ready,
    input logic          res_valid,
    input logic          res_ready,
    input csg_pkg::res_t res
);

    // result word holds until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result word dropped or changed while stalled");

    // one word in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("second word accepted while busy");

    a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.tiles_loaded <= 5'(csg_pkg::MAX_TILES))
        else $error("loaded chunk count above table size");

    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.tiles_live <= res.tiles_loaded)
        else $error("active chunks exceed loaded chunks");

endmodule

bind chunked_sparse_grid_cell_store_top csg_checker u_csg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// random and directed cell, chunk and step words against a grid store
// predictor; results checked in order, field by field, under random idling
// ----------------------------------------------------------------------------
module testbench;

    localparam int QUIET_LIMIT = 50000;

    logic          clk;
    logic          rst_n;
    logic          cmd_valid;
    logic          cmd_ready;
    csg_pkg::cmd_t cmd;
    logic          res_valid;
    logic          res_ready;
    csg_pkg::res_t res;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [csg_pkg::PADDR_W-1:0] paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    int send_idle;
    int recv_stall;
    int quiet;
    logic signed [31:0] pool_x [20];
    logic signed [31:0] pool_y [20];

    chunked_sparse_grid_cell_store_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    class grid_scoreboard;
        csg_pkg::res_t pending [$];
        int          errors;
        logic [15:0] max_material;
        logic [63:0] tile_key [csg_pkg::MAX_TILES];
        int          tile_slot [csg_pkg::MAX_TILES];
        int          entries;
        bit          slot_free [csg_pkg::MAX_TILES];
        logic [15:0] cells [csg_pkg::MEM_DEPTH];
        int          tile_live [csg_pkg::MAX_TILES];
        int          live_sum;
        int          active;
        logic [63:0] steps;

        function new();
            errors = 0;
            max_material = '0;
            entries = 0;
            live_sum = 0;
            active = 0;
            steps = '0;
            for (int i = 0; i < csg_pkg::MAX_TILES; i++)
            begin
                slot_free[i] = 1'b1;
                tile_live[i] = 0;
            end
            for (int i = 0; i < csg_pkg::MEM_DEPTH; i++)
                cells[i] = '0;
        endfunction

        function int find_tile(logic [63:0] key);
            for (int i = 0; i < entries; i++)
                if (tile_key[i] == key)
                    return i;
            return -1;
        endfunction

        function int cell_addr(logic signed [31:0] cx, logic signed [31:0] cy);
            int e;
            e = find_tile({cx >>> csg_pkg::TILE_WIDTH_LOG2, cy >>> csg_pkg::TILE_HEIGHT_LOG2});
            if (e < 0)
                return -1;
            return tile_slot[e] * csg_pkg::CELLS
                 + ((cy & ((1 << csg_pkg::TILE_HEIGHT_LOG2) - 1)) << csg_pkg::TILE_WIDTH_LOG2)
                 + (cx & ((1 << csg_pkg::TILE_WIDTH_LOG2) - 1));
        endfunction

        function logic [1:0] write_cell(logic signed [31:0] cx, logic signed [31:0] cy,
                                        logic [15:0] v);
            int a;
            int s;
            logic [15:0] old;
            a = cell_addr(cx, cy);
            if (a < 0)
                return csg_pkg::STAT_NOT_FOUND;
            s = a / csg_pkg::CELLS;
            old = cells[a];
            cells[a] = v;
            if (old == 0 && v != 0)
            begin
                live_sum++;
                tile_live[s]++;
                if (tile_live[s] == 1)
                    active++;
            end
            else if (old != 0 && v == 0)
            begin
                if (live_sum > 0)
                    live_sum--;
                if (tile_live[s] > 0)
                begin
                    tile_live[s]--;
                    if (tile_live[s] == 0 && active > 0)
                        active--;
                end
            end
            return csg_pkg::STAT_OK;
        endfunction

        function void note(csg_pkg::cmd_t c);
            csg_pkg::res_t r;
            int a;
            int e;
            int s;
            logic [63:0] key;
            r = '0;
            key = {c.tile_x, c.tile_y};
            case (c.opcode)
                csg_pkg::OP_GET:
                begin
                    a = cell_addr(c.cell_x, c.cell_y);
                    if (a < 0)
                        r.status = csg_pkg::STAT_NOT_FOUND;
                    else
                    begin
                        r.read_material = cells[a];
                        if (cells[a] != 0 && cells[a] > max_material)
                            r.status = csg_pkg::STAT_NOT_FOUND;
                    end
                end
                csg_pkg::OP_SET:
                begin
                    if (c.write_id != 0 && c.write_id > max_material)
                        r.status = csg_pkg::STAT_NOT_FOUND;
                    else
                        r.status = write_cell(c.cell_x, c.cell_y, c.write_id);
                end
                csg_pkg::OP_CLEAR:
                    r.status = write_cell(c.cell_x, c.cell_y, '0);
                csg_pkg::OP_LOAD:
                begin
                    if (find_tile(key) >= 0)
                        r.status = csg_pkg::STAT_EXISTS;
                    else
                    begin
                        s = 0;
                        while (s < csg_pkg::MAX_TILES && !slot_free[s])
                            s++;
                        if (entries >= csg_pkg::MAX_TILES || s >= csg_pkg::MAX_TILES)
                            r.status = csg_pkg::STAT_FULL;
                        else
                        begin
                            slot_free[s] = 1'b0;
                            for (int i = 0; i < csg_pkg::CELLS; i++)
                                cells[s * csg_pkg::CELLS + i] = '0;
                            tile_live[s] = 0;
                            tile_key[entries] = key;
                            tile_slot[entries] = s;
                            entries++;
                        end
                    end
                end
                csg_pkg::OP_UNLOAD:
                begin
                    e = find_tile(key);
                    if (e < 0)
                        r.status = csg_pkg::STAT_NOT_FOUND;
                    else
                    begin
                        s = tile_slot[e];
                        if (tile_live[s] > 0)
                        begin
                            live_sum = (live_sum >= tile_live[s]) ? live_sum - tile_live[s] : 0;
                            if (active > 0)
                                active--;
                        end
                        tile_live[s] = 0;
                        slot_free[s] = 1'b1;
                        if (e + 1 < entries)
                        begin
                            tile_key[e] = tile_key[entries - 1];
                            tile_slot[e] = tile_slot[entries - 1];
                        end
                        entries--;
                    end
                end
                csg_pkg::OP_STEP:
                    steps = steps + ((c.substeps == 0) ? 64'd1 : {32'd0, c.substeps});
                default:
                    ;
            endcase
            r.tiles_loaded = 5'(entries);
            r.tiles_live = 5'(active);
            r.live_total = 17'(live_sum);
            r.step_total = steps;
            pending.push_back(r);
        endfunction

        task report(string what);
            $display("ERROR: %s", what);
            errors++;
        endtask

        task check(csg_pkg::res_t got);
            csg_pkg::res_t want;
            if (pending.size() == 0)
            begin
                report("result word with no expectation");
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.read_material !== want.read_material)
                report($sformatf("read_material %0d, want %0d",
                                 got.read_material, want.read_material));
            if (got.tiles_loaded !== want.tiles_loaded)
                report($sformatf("tiles_loaded %0d, want %0d",
                                 got.tiles_loaded, want.tiles_loaded));
            if (got.tiles_live !== want.tiles_live)
                report($sformatf("tiles_live %0d, want %0d",
                                 got.tiles_live, want.tiles_live));
            if (got.live_total !== want.live_total)
                report($sformatf("live_total %0d, want %0d", got.live_total, want.live_total));
            if (got.step_total !== want.step_total)
                report($sformatf("step_total %0h, want %0h", got.step_total, want.step_total));
        endtask
    endclass

    grid_scoreboard sb;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(negedge clk)
        res_ready <= ($urandom_range(0, 99) >= recv_stall);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && res_ready)
                sb.check(res);
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("chunked_sparse_grid_cell_store_top: mismatch");
                $finish;
            end
        end
    end

    function csg_pkg::cmd_t mk(logic [2:0] op, logic [31:0] cx, logic [31:0] cy,
                               logic [31:0] tx, logic [31:0] ty, logic [15:0] nm,
                               logic [31:0] sub);
        csg_pkg::cmd_t c;
        c.opcode = op;
        c.cell_x = cx;
        c.cell_y = cy;
        c.tile_x = tx;
        c.tile_y = ty;
        c.write_id = nm;
        c.substeps = sub;
        return c;
    endfunction

    task send(csg_pkg::cmd_t c);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (!cmd_ready);
        sb.note(c);
    endtask

    task drain();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task write_materials(logic [15:0] v);
        drain();
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= csg_pkg::PADDR_W'(4 * int'(csg_pkg::REG_MATERIALS));
        pwdata <= {16'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.max_material = v;
    endtask

    function logic [31:0] in_tile(logic [31:0] t, int lg);
        return (t << lg) | $urandom_range(0, (1 << lg) - 1);
    endfunction

    function logic [15:0] pick_material(logic [15:0] top);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20 && top != 16'hffff)
            return 16'($urandom_range(top + 1, 65535));
        if (r < 25)
            return 16'($urandom);
        if (top == 0)
            return '0;
        if (r < 35)
            return top;
        return 16'($urandom_range(1, top));
    endfunction

    function csg_pkg::cmd_t random_word(logic [15:0] top);
        csg_pkg::cmd_t c;
        int r;
        int k;
        c = '0;
        c.substeps = $urandom;
        c.write_id = pick_material(top);
        k = $urandom_range(0, 19);
        c.cell_x = in_tile(pool_x[k], csg_pkg::TILE_WIDTH_LOG2);
        c.cell_y = in_tile(pool_y[k], csg_pkg::TILE_HEIGHT_LOG2);
        c.tile_x = pool_x[k];
        c.tile_y = pool_y[k];
        r = $urandom_range(0, 99);
        if (r < 30)
            c.opcode = csg_pkg::OP_SET;
        else if (r < 55)
            c.opcode = csg_pkg::OP_GET;
        else if (r < 64)
            c.opcode = csg_pkg::OP_CLEAR;
        else if (r < 70)
            c.opcode = csg_pkg::OP_LOAD;
        else if (r < 74)
            c.opcode = csg_pkg::OP_UNLOAD;
        else if (r < 84)
        begin
            c.opcode = csg_pkg::OP_STEP;
            if ($urandom_range(0, 3) == 0)
                c.substeps = '0;
        end
        else if (r < 88)
            c.opcode = 3'($urandom_range(6, 7));
        else
        begin
            c.opcode = 3'($urandom_range(0, 7));
            c.cell_x = $urandom;
            c.cell_y = $urandom;
            c.tile_x = $urandom;
            c.tile_y = $urandom;
            c.write_id = 16'($urandom);
        end
        return c;
    endfunction

    initial
    begin
        csg_pkg::cmd_t c;
        int done;
        logic [15:0] phase_top [6];

        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        res_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle = 0;
        recv_stall = 0;
        quiet = 0;
        sb = new();
        pool_x[0] = 0;            pool_y[0] = 0;
        pool_x[1] = -1;           pool_y[1] = -1;
        pool_x[2] = 33554431;     pool_y[2] = -33554432;
        pool_x[3] = -33554432;    pool_y[3] = 33554431;
        pool_x[4] = 1;            pool_y[4] = -1;
        for (int i = 5; i < 20; i++)
        begin
            pool_x[i] = $urandom_range(0, 16) - 8;
            pool_y[i] = $urandom_range(0, 16) - 8;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // register at zero: every lookup misses, nonzero sets are refused
        send(mk(csg_pkg::OP_GET, 32'd5, 32'd5, 0, 0, 0, 0));
        send(mk(csg_pkg::OP_SET, 32'd5, 32'd5, 0, 0, 16'd5, 0));
        send(mk(csg_pkg::OP_SET, 32'd5, 32'd5, 0, 0, 16'd0, 0));
        send(mk(csg_pkg::OP_CLEAR, 32'd5, 32'd5, 0, 0, 0, 0));
        send(mk(csg_pkg::OP_UNLOAD, 0, 0, 32'd3, 32'd3, 0, 0));
        send(mk(csg_pkg::OP_LOAD, 0, 0, 32'd0, 32'd0, 0, 0));
        send(mk(csg_pkg::OP_LOAD, 0, 0, 32'd0, 32'd0, 0, 0));
        send(mk(csg_pkg::OP_STEP, 0, 0, 0, 0, 0, 32'd0));
        send(mk(csg_pkg::OP_STEP, 0, 0, 0, 0, 0, 32'hffffffff));
        send(mk(3'd6, 32'hffffffff, 32'h80000000, 32'hffffffff, 32'hffffffff, 16'hffff,
                32'hffffffff));
        send(mk(3'd7, 0, 0, 0, 0, 0, 0));
        write_materials(16'hffff);
        send(mk(csg_pkg::OP_LOAD, 0, 0, 32'd33554431, 32'd33554431, 0, 0));
        send(mk(csg_pkg::OP_LOAD, 0, 0, 32'hfe000000, 32'hfe000000, 0, 0));
        send(mk(csg_pkg::OP_LOAD, 0, 0, 32'h7fffffff, 32'h80000000, 0, 0));
        send(mk(csg_pkg::OP_SET, 32'h7fffffff, 32'h7fffffff, 0, 0, 16'hffff, 0));
        send(mk(csg_pkg::OP_SET, 32'h80000000, 32'h80000000, 0, 0, 16'd1, 0));
        send(mk(csg_pkg::OP_SET, 32'd0, 32'd0, 0, 0, 16'hffff, 0));
        send(mk(csg_pkg::OP_GET, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0));
        send(mk(csg_pkg::OP_CLEAR, 32'd1, 32'd0, 0, 0, 0, 0));
        send(mk(csg_pkg::OP_SET, 32'h80000000, 32'h80000000, 0, 0, 16'd0, 0));
        send(mk(csg_pkg::OP_UNLOAD, 0, 0, 32'd33554431, 32'd33554431, 0, 0));
        write_materials(16'd1);
        // stale id left behind by lowering the register
        send(mk(csg_pkg::OP_GET, 32'd0, 32'd0, 0, 0, 0, 0));
        send(mk(csg_pkg::OP_UNLOAD, 0, 0, 32'h7fffffff, 32'h80000000, 0, 0));

        phase_top[0] = 16'hffff;
        phase_top[1] = 16'd3;
        phase_top[2] = 16'd0;
        phase_top[3] = 16'($urandom_range(1, 65534));
        phase_top[4] = 16'd1000;
        phase_top[5] = 16'hffff;
        for (int p = 0; p < 6; p++)
        begin
            write_materials(phase_top[p]);
            send_idle = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 3) ? 28 : 49) : 0;
            recv_stall = (p % 4 == 2 || p % 4 == 3) ? ((p % 4 == 3) ? 28 : 49) : 0;
            done = 0;
            while (done < 300)
            begin
                c = random_word(phase_top[p]);
                send(c);
                if (c.opcode <= csg_pkg::OP_STEP)
                    done++;
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("chunked_sparse_grid_cell_store_top: match");
        else
            $display("chunked_sparse_grid_cell_store_top: mismatch");
        $finish;
    end
endmodule
